// ----- rtl/core/indexed_sprite_blitter_assert.svh -----
// Assertion macros for the indexed sprite blitter checkers.
`ifndef INDEXED_SPRITE_BLITTER_ASSERT_SVH
`define INDEXED_SPRITE_BLITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ISB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/isb_pkg.sv -----
// Shared types and constants of the indexed sprite blitter.
package isb_pkg;

    localparam int MAX_DIM         = 2048;
    localparam int ADDR_WIDTH      = 24;
    localparam int PALETTE_ENTRIES = 256;

    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int DIMV_W   = (DIM_W + 1 > 12) ? DIM_W + 1 : 12;
    localparam int COORD_W  = ((DIM_W > 12) ? DIM_W : 12) + 2;
    localparam int CANVAS_W = 12;
    localparam int PITCH_W  = 13;
    localparam int PROD_W   = CANVAS_W + PITCH_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int TIDX_W   = $clog2(PALETTE_ENTRIES);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [1:0] MODE_PIXEL    = 2'd0;
    localparam logic [1:0] MODE_LOAD_PAL = 2'd1;
    localparam logic [1:0] MODE_LOAD_MAP = 2'd2;

    localparam int OPT_KEY    = 0;
    localparam int OPT_SHADOW = 1;
    localparam int OPT_REMAP  = 2;

    localparam logic [7:0]  KEY_INDEX    = 8'd0;
    localparam logic [7:0]  SHADOW_INDEX = 8'd4;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
    localparam logic [23:0] SHADOW_MASK  = 24'h7f7f7f;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH     = 3'd0,
        REG_SRC_HEIGHT    = 3'd1,
        REG_DEST_X        = 3'd2,
        REG_DEST_Y        = 3'd3,
        REG_CANVAS_WIDTH  = 3'd4,
        REG_CANVAS_HEIGHT = 3'd5,
        REG_CANVAS_PITCH  = 3'd6,
        REG_OPTION_FLAGS  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_SKIP    = 3'd0,
        K_LD_PAL  = 3'd1,
        K_LD_MAP  = 3'd2,
        K_SHADOW  = 3'd3,
        K_PAL     = 3'd4,
        K_PAL_MAP = 3'd5
    } t_kind;

    typedef struct packed {
        logic [11:0]        src_width;
        logic [11:0]        src_height;
        logic signed [11:0] dest_x;
        logic signed [11:0] dest_y;
        logic [11:0]        canvas_width;
        logic [11:0]        canvas_height;
        logic [12:0]        canvas_pitch;
        logic [2:0]         option_flags;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  table_index;
        logic [23:0] table_data;
        logic [7:0]  src_index;
        logic [31:0] dest_pixel;
    } t_in;

    typedef struct packed {
        logic                  write_enable;
        logic [ADDR_WIDTH-1:0] address;
        logic [31:0]           pixel_data;
        logic                  last;
    } t_out;

    typedef struct packed {
        t_kind               kind;
        logic [TIDX_W-1:0]   index;
        logic [23:0]         data;
        logic [CANVAS_W-1:0] tx;
        logic [CANVAS_W-1:0] ty;
        logic                last;
    } t_cmd;

endpackage

// ----- rtl/core/isb_cmd_queue.sv -----
// Short command queue between the front and the back of the blitter.
module isb_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  isb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output isb_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);

    isb_pkg::t_cmd                 r_mem [isb_pkg::CQ_DEPTH];
    logic [isb_pkg::CQ_PTR_W-1:0]  r_wr;
    logic [isb_pkg::CQ_PTR_W-1:0]  r_rd;
    logic [isb_pkg::CQ_CNT_W-1:0]  r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_cnt == isb_pkg::CQ_CNT_W'(isb_pkg::CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/isb_front.sv -----
// Front of the blitter: raster counters, clipping and item classification.
module isb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  isb_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  isb_pkg::t_in  i_item,
    output isb_pkg::t_cmd o_cmd
);

    function automatic logic [isb_pkg::DIMV_W-1:0] dim_m1(input logic [11:0] v);
        logic [isb_pkg::DIMV_W-1:0] ext;
        ext = isb_pkg::DIMV_W'(v);
        if (ext == '0) begin
            dim_m1 = '0;
        end else if (ext > isb_pkg::DIMV_W'(isb_pkg::MAX_DIM)) begin
            dim_m1 = isb_pkg::DIMV_W'(isb_pkg::MAX_DIM - 1);
        end else begin
            dim_m1 = ext - 1'b1;
        end
    endfunction

    logic [isb_pkg::DIM_W-1:0]   r_col;
    logic [isb_pkg::DIM_W-1:0]   r_row;
    logic [isb_pkg::DIM_W-1:0]   n_col;
    logic [isb_pkg::DIM_W-1:0]   n_row;
    logic [isb_pkg::COORD_W-1:0] tx;
    logic [isb_pkg::COORD_W-1:0] ty;
    logic                        visible;
    logic                        end_row;
    logic                        end_all;

    always_comb begin
        tx = isb_pkg::COORD_W'(i_cfg.dest_x) + isb_pkg::COORD_W'(r_col);
        ty = isb_pkg::COORD_W'(i_cfg.dest_y) + isb_pkg::COORD_W'(r_row);
        visible = !tx[isb_pkg::COORD_W-1] && !ty[isb_pkg::COORD_W-1]
            && (tx < isb_pkg::COORD_W'(i_cfg.canvas_width))
            && (ty < isb_pkg::COORD_W'(i_cfg.canvas_height));
        end_row = isb_pkg::DIMV_W'(r_col) >= dim_m1(i_cfg.src_width);
        end_all = end_row && (isb_pkg::DIMV_W'(r_row) >= dim_m1(i_cfg.src_height));

        n_col = r_col;
        n_row = r_row;
        o_cmd.kind  = isb_pkg::K_SKIP;
        o_cmd.index = i_item.src_index;
        o_cmd.data  = '0;
        o_cmd.tx    = tx[isb_pkg::CANVAS_W-1:0];
        o_cmd.ty    = ty[isb_pkg::CANVAS_W-1:0];
        o_cmd.last  = 1'b0;

        case (i_item.mode)
            isb_pkg::MODE_LOAD_PAL: begin
                o_cmd.kind  = isb_pkg::K_LD_PAL;
                o_cmd.index = i_item.table_index;
                o_cmd.data  = i_item.table_data;
            end
            isb_pkg::MODE_LOAD_MAP: begin
                o_cmd.kind  = isb_pkg::K_LD_MAP;
                o_cmd.index = i_item.table_index;
                o_cmd.data  = i_item.table_data;
            end
            isb_pkg::MODE_PIXEL: begin
                o_cmd.last = end_all;
                if (visible) begin
                    if (i_cfg.option_flags[isb_pkg::OPT_KEY]
                            && i_item.src_index == isb_pkg::KEY_INDEX) begin
                        o_cmd.kind = isb_pkg::K_SKIP;
                    end else if (i_cfg.option_flags[isb_pkg::OPT_SHADOW]
                            && i_item.src_index == isb_pkg::SHADOW_INDEX) begin
                        o_cmd.kind = isb_pkg::K_SHADOW;
                        o_cmd.data = i_item.dest_pixel[24:1] & isb_pkg::SHADOW_MASK;
                    end else if (i_cfg.option_flags[isb_pkg::OPT_REMAP]) begin
                        o_cmd.kind = isb_pkg::K_PAL_MAP;
                    end else begin
                        o_cmd.kind = isb_pkg::K_PAL;
                    end
                end
                if (end_all) begin
                    n_col = '0;
                    n_row = '0;
                end else if (end_row) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- rtl/core/isb_back.sv -----
// Back of the blitter: table stores, address arithmetic and the result queue.
module isb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  isb_pkg::t_cfg i_cfg,
    input  logic          i_cq_empty,
    input  isb_pkg::t_cmd i_head,
    output logic          o_cq_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output isb_pkg::t_out o_result
);

    logic [isb_pkg::TIDX_W-1:0] r_remap   [isb_pkg::PALETTE_ENTRIES];
    logic [23:0]                r_palette [isb_pkg::PALETTE_ENTRIES];

    logic [isb_pkg::TIDX_W-1:0] r_map_q;
    logic [23:0]                r_pal_q;
    logic [isb_pkg::TIDX_W-1:0] pal_addr;

    logic                        r_s1_v;
    isb_pkg::t_cmd               r_s1;
    logic [isb_pkg::PROD_W-1:0]  r_prod;
    logic                        r_s2_v;
    isb_pkg::t_cmd               r_s2;
    logic [isb_pkg::SUM_W-1:0]   r_sum;

    isb_pkg::t_out                                  res;
    logic [isb_pkg::SUM_W+isb_pkg::ADDR_WIDTH-1:0]  addr_ext;

    isb_pkg::t_out                 r_oq [isb_pkg::OQ_DEPTH];
    logic [isb_pkg::OQ_PTR_W-1:0]  r_oq_wr;
    logic [isb_pkg::OQ_PTR_W-1:0]  r_oq_rd;
    logic [isb_pkg::OQ_CNT_W-1:0]  r_oq_cnt;
    logic [isb_pkg::OQ_CNT_W:0]    pending;
    logic                          oq_pop;

    assign pending  = (isb_pkg::OQ_CNT_W + 1)'(r_oq_cnt) + (isb_pkg::OQ_CNT_W + 1)'(r_s1_v)
        + (isb_pkg::OQ_CNT_W + 1)'(r_s2_v);
    assign o_cq_pop = !i_cq_empty && (pending < (isb_pkg::OQ_CNT_W + 1)'(isb_pkg::OQ_DEPTH));
    assign pal_addr = (r_s1.kind == isb_pkg::K_PAL_MAP) ? r_map_q : r_s1.index;

    always_ff @(posedge i_clk) begin
        if (o_cq_pop && i_head.kind == isb_pkg::K_LD_MAP) begin
            r_remap[i_head.index] <= i_head.data[isb_pkg::TIDX_W-1:0];
        end
        r_map_q <= r_remap[i_head.index];
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v && r_s1.kind == isb_pkg::K_LD_PAL) begin
            r_palette[r_s1.index] <= r_s1.data;
        end
        r_pal_q <= r_palette[pal_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1   <= i_head;
        r_prod <= isb_pkg::PROD_W'(i_head.ty) * isb_pkg::PROD_W'(i_cfg.canvas_pitch);
        r_s2   <= r_s1;
        r_sum  <= isb_pkg::SUM_W'(r_prod) + isb_pkg::SUM_W'(r_s1.tx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= o_cq_pop;
            r_s2_v <= r_s1_v;
        end
    end

    always_comb begin
        addr_ext = {{isb_pkg::ADDR_WIDTH{1'b0}}, r_sum};
        res      = '0;
        res.last = r_s2.last;
        case (r_s2.kind)
            isb_pkg::K_PAL, isb_pkg::K_PAL_MAP: begin
                res.write_enable = 1'b1;
                res.address      = addr_ext[isb_pkg::ADDR_WIDTH-1:0];
                res.pixel_data   = {isb_pkg::ALPHA_OPAQUE, r_pal_q};
            end
            isb_pkg::K_SHADOW: begin
                res.write_enable = 1'b1;
                res.address      = addr_ext[isb_pkg::ADDR_WIDTH-1:0];
                res.pixel_data   = {isb_pkg::ALPHA_OPAQUE, r_s2.data};
            end
            default: begin
            end
        endcase
    end

    assign o_empty  = (r_oq_cnt == '0);
    assign oq_pop   = i_pop && !o_empty;
    assign o_result = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_oq[r_oq_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s2_v) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            if (r_s2_v && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (oq_pop && !r_s2_v) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/indexed_sprite_blitter.sv -----
// Top level of the indexed sprite blitter: configuration registers and the two halves.
//
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------------
//  input     push / full          i_item   (mode, table entry, pixel)
//  result    empty / pop          o_result (write_enable, address, data, last)
//  config    i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One item per clock is sustained; the command queue and the result queue keep
// the front and the back running whenever the result side pops every cycle.
// An accepted item passes, unless a queue stalls it, through the queue pop with the remap
// read and pitch multiply, the palette read with the address add, then the result queue.
// Reset is synchronous and clears the counters and both queues; table entries
// hold nothing until loaded.
module indexed_sprite_blitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  isb_pkg::t_in                      i_item,
    output logic                              empty,
    input  logic                              pop,
    output isb_pkg::t_out                     o_result,
    input  logic                              i_cfg_wr_en,
    input  logic [isb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [isb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    isb_pkg::t_cfg r_cfg;
    isb_pkg::t_cmd front_cmd;
    isb_pkg::t_cmd cq_head;
    logic          cq_empty;
    logic          cq_pop;
    logic          accept;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width     <= 12'd1;
            r_cfg.src_height    <= 12'd1;
            r_cfg.dest_x        <= '0;
            r_cfg.dest_y        <= '0;
            r_cfg.canvas_width  <= 12'd1;
            r_cfg.canvas_height <= 12'd1;
            r_cfg.canvas_pitch  <= 13'd1;
            r_cfg.option_flags  <= '0;
        end else if (i_cfg_wr_en) begin
            case (isb_pkg::t_cfg_idx'(i_cfg_index))
                isb_pkg::REG_SRC_WIDTH:     r_cfg.src_width     <= i_cfg_data[11:0];
                isb_pkg::REG_SRC_HEIGHT:    r_cfg.src_height    <= i_cfg_data[11:0];
                isb_pkg::REG_DEST_X:        r_cfg.dest_x        <= i_cfg_data[11:0];
                isb_pkg::REG_DEST_Y:        r_cfg.dest_y        <= i_cfg_data[11:0];
                isb_pkg::REG_CANVAS_WIDTH:  r_cfg.canvas_width  <= i_cfg_data[11:0];
                isb_pkg::REG_CANVAS_HEIGHT: r_cfg.canvas_height <= i_cfg_data[11:0];
                isb_pkg::REG_CANVAS_PITCH:  r_cfg.canvas_pitch  <= i_cfg_data[12:0];
                isb_pkg::REG_OPTION_FLAGS:  r_cfg.option_flags  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    isb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_item   (i_item),
        .o_cmd    (front_cmd)
    );

    isb_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (cq_pop),
        .o_head  (cq_head),
        .o_full  (full),
        .o_empty (cq_empty)
    );

    isb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cq_empty (cq_empty),
        .i_head     (cq_head),
        .o_cq_pop   (cq_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/core/isb_checker.sv -----
// Port-level checker for the indexed sprite blitter, bound to the top level.
`include "indexed_sprite_blitter_assert.svh"

module isb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_push,
    input logic          i_full,
    input logic          i_empty,
    input logic          i_pop,
    input isb_pkg::t_out i_result
);

    `ISB_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, i_empty && !i_full, "Queues not cleared by reset.")

    `ISB_ASSERT_NOW(a_skip_is_zero, i_clk, i_rst_n, !i_empty && !i_result.write_enable, i_result.address == '0 && i_result.pixel_data == '0, "Skipped item carries address or data.")

    `ISB_ASSERT_NOW(a_write_opaque, i_clk, i_rst_n, !i_empty && i_result.write_enable, i_result.pixel_data[31:24] == isb_pkg::ALPHA_OPAQUE, "Written pixel is not opaque.")

    `ISB_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !i_empty && !i_pop, !i_empty && $stable(i_result), "Stalled result changed.")

endmodule

bind indexed_sprite_blitter isb_checker u_isb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_push   (push),
    .i_full   (full),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);

// ----- dv/indexed_sprite_blitter_test.sv -----
// Self-checking testbench of the indexed sprite blitter against a cycle-free pixel predictor.
`timescale 1ns / 100ps

module indexed_sprite_blitter_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 44;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic {ROW_ITEM, ROW_SETTING} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        isb_pkg::t_cfg_idx              reg_sel;
        logic [isb_pkg::CFG_DATA_W-1:0] value;
        isb_pkg::t_in                   item;
        bit                             typed;
        isb_pkg::t_out                  want;
    } t_stim_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           push        = 1'b0;
    logic                           full;
    isb_pkg::t_in                   i_item      = '0;
    logic                           empty;
    logic                           pop         = 1'b0;
    isb_pkg::t_out                  o_result;
    logic                           i_cfg_wr_en = 1'b0;
    logic [isb_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [isb_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    indexed_sprite_blitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    int unsigned   tx_idle_pct = 22;
    int unsigned   rx_idle_pct = 65;
    bit            item_typed  = 1'b0;
    isb_pkg::t_out item_want   = '0;
    bit            pal_loaded [256];
    bit            map_loaded [256];
    logic [7:0]    planned_map [256];
    logic [2:0]    planned_flags = '0;

    isb_pkg::t_cfg blit_cfg;
    logic [23:0]   palette_copy [256];
    logic [7:0]    remap_copy [256];
    logic [10:0]   column_count;
    logic [10:0]   row_count;
    isb_pkg::t_out pixel_q [$];
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) pop = ($urandom_range(99) >= rx_idle_pct);

    function automatic int sprite_extent(input logic [11:0] v);
        if (v == 12'd0) return 1;
        if (int'(v) > isb_pkg::MAX_DIM) return isb_pkg::MAX_DIM;
        return int'(v);
    endfunction

    function automatic isb_pkg::t_out blit_step(input isb_pkg::t_in it);
        isb_pkg::t_out res;
        int            w;
        int            h;
        int            tx;
        int            ty;
        longint        offset;
        logic [7:0]    idx;
        bit            end_row;
        bit            end_all;
        res = '0;
        case (it.mode)
            isb_pkg::MODE_LOAD_PAL: palette_copy[it.table_index] = it.table_data;
            isb_pkg::MODE_LOAD_MAP: remap_copy[it.table_index] = it.table_data[7:0];
            isb_pkg::MODE_PIXEL: begin
                w  = sprite_extent(blit_cfg.src_width);
                h  = sprite_extent(blit_cfg.src_height);
                tx = $signed(blit_cfg.dest_x) + $signed({1'b0, column_count});
                ty = $signed(blit_cfg.dest_y) + $signed({1'b0, row_count});
                if (tx >= 0 && ty >= 0 && tx < int'(blit_cfg.canvas_width) &&
                        ty < int'(blit_cfg.canvas_height)) begin
                    idx = it.src_index;
                    if (blit_cfg.option_flags[isb_pkg::OPT_KEY]
                            && idx == isb_pkg::KEY_INDEX) begin
                        res.write_enable = 1'b0;
                    end else if (blit_cfg.option_flags[isb_pkg::OPT_SHADOW]
                            && idx == isb_pkg::SHADOW_INDEX) begin
                        res.write_enable = 1'b1;
                        res.pixel_data   = {isb_pkg::ALPHA_OPAQUE,
                                            it.dest_pixel[24:1] & isb_pkg::SHADOW_MASK};
                    end else begin
                        if (blit_cfg.option_flags[isb_pkg::OPT_REMAP]) idx = remap_copy[idx];
                        res.write_enable = 1'b1;
                        res.pixel_data   = {isb_pkg::ALPHA_OPAQUE, palette_copy[idx]};
                    end
                    if (res.write_enable) begin
                        offset = longint'(ty) * longint'(blit_cfg.canvas_pitch) + longint'(tx);
                        res.address = offset[isb_pkg::ADDR_WIDTH-1:0];
                    end
                end
                end_row  = int'(column_count) >= w - 1;
                end_all  = end_row && int'(row_count) >= h - 1;
                res.last = end_all;
                if (end_all) begin
                    column_count = '0;
                    row_count    = '0;
                end else if (end_row) begin
                    column_count = '0;
                    row_count    = row_count + 1'b1;
                end else begin
                    column_count = column_count + 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_failure(input string what, input isb_pkg::t_out want,
                                input isb_pkg::t_out got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected we=%0b addr=%h data=%h last=%0b", $time, what,
                     want.write_enable, want.address, want.pixel_data, want.last);
            $display("        got      we=%0b addr=%h data=%h last=%0b",
                     got.write_enable, got.address, got.pixel_data, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        isb_pkg::t_out predicted;
        isb_pkg::t_out want;
        if (!i_rst_n) begin
            blit_cfg = '0;
            blit_cfg.src_width     = 12'd1;
            blit_cfg.src_height    = 12'd1;
            blit_cfg.canvas_width  = 12'd1;
            blit_cfg.canvas_height = 12'd1;
            blit_cfg.canvas_pitch  = 13'd1;
            column_count = '0;
            row_count    = '0;
            for (int n = 0; n < 256; n++) begin
                palette_copy[n] = '0;
                remap_copy[n]   = '0;
            end
            pixel_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (isb_pkg::t_cfg_idx'(i_cfg_index))
                    isb_pkg::REG_SRC_WIDTH:     blit_cfg.src_width     = i_cfg_data[11:0];
                    isb_pkg::REG_SRC_HEIGHT:    blit_cfg.src_height    = i_cfg_data[11:0];
                    isb_pkg::REG_DEST_X:        blit_cfg.dest_x        = i_cfg_data[11:0];
                    isb_pkg::REG_DEST_Y:        blit_cfg.dest_y        = i_cfg_data[11:0];
                    isb_pkg::REG_CANVAS_WIDTH:  blit_cfg.canvas_width  = i_cfg_data[11:0];
                    isb_pkg::REG_CANVAS_HEIGHT: blit_cfg.canvas_height = i_cfg_data[11:0];
                    isb_pkg::REG_CANVAS_PITCH:  blit_cfg.canvas_pitch  = i_cfg_data[12:0];
                    isb_pkg::REG_OPTION_FLAGS:  blit_cfg.option_flags  = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                predicted = blit_step(i_item);
                pixel_q.push_back(item_typed ? item_want : predicted);
            end
            if (pop && !empty) begin
                if (pixel_q.size() == 0) begin
                    note_failure("result with nothing expected", '0, o_result);
                end else begin
                    want = pixel_q.pop_front();
                    if (o_result.write_enable !== want.write_enable ||
                            o_result.address !== want.address ||
                            o_result.pixel_data !== want.pixel_data ||
                            o_result.last !== want.last) begin
                        note_failure("result mismatch", want, o_result);
                    end
                end
            end
        end
    end

    task automatic send_item(input isb_pkg::t_in it, input bit typed, input isb_pkg::t_out want);
        i_cfg_wr_en = 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push       = 1'b1;
        i_item     = it;
        item_typed = typed;
        item_want  = want;
        case (it.mode)
            isb_pkg::MODE_LOAD_PAL: pal_loaded[it.table_index] = 1'b1;
            isb_pkg::MODE_LOAD_MAP: begin
                map_loaded[it.table_index]  = 1'b1;
                planned_map[it.table_index] = it.table_data[7:0];
            end
            default: ;
        endcase
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        push        = 1'b0;
        i_cfg_wr_en = 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_setting(input isb_pkg::t_cfg_idx sel,
                                 input logic [isb_pkg::CFG_DATA_W-1:0] value);
        push        = 1'b0;
        i_cfg_wr_en = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = value;
        if (sel == isb_pkg::REG_OPTION_FLAGS) planned_flags = value[2:0];
        @(negedge i_clk);
    endtask

    function automatic logic [isb_pkg::CFG_DATA_W-1:0] pick_size(input int unsigned common_max);
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'd2048;
            2: return 13'd4095;
            3: return 13'($urandom_range(4095));
            default: return 13'($urandom_range(common_max, 1));
        endcase
    endfunction

    function automatic logic [isb_pkg::CFG_DATA_W-1:0] pick_position();
        int d;
        d = int'($urandom_range(16)) - 8;
        case ($urandom_range(9))
            0: return 13'h0800;
            1: return 13'h07ff;
            2: return 13'($urandom_range(4095));
            default: return {1'b0, d[11:0]};
        endcase
    endfunction

    function automatic logic [isb_pkg::CFG_DATA_W-1:0] pick_pitch();
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'd8191;
            3: return 13'($urandom_range(8191));
            default: return 13'($urandom_range(16, 1));
        endcase
    endfunction

    task automatic program_phase(input int unsigned phase);
        wait_idle();
        if (phase == 0) begin
            write_setting(isb_pkg::REG_SRC_WIDTH, 13'd2048);
            write_setting(isb_pkg::REG_SRC_HEIGHT, 13'd2048);
            write_setting(isb_pkg::REG_DEST_X, 13'h07ff);
            write_setting(isb_pkg::REG_DEST_Y, 13'h07ff);
            write_setting(isb_pkg::REG_CANVAS_WIDTH, 13'd4095);
            write_setting(isb_pkg::REG_CANVAS_HEIGHT, 13'd4095);
            write_setting(isb_pkg::REG_CANVAS_PITCH, 13'd8191);
            write_setting(isb_pkg::REG_OPTION_FLAGS, 13'd7);
        end else if (phase == 1) begin
            write_setting(isb_pkg::REG_SRC_WIDTH, 13'd0);
            write_setting(isb_pkg::REG_SRC_HEIGHT, 13'd0);
            write_setting(isb_pkg::REG_DEST_X, 13'd0);
            write_setting(isb_pkg::REG_DEST_Y, 13'd0);
            write_setting(isb_pkg::REG_CANVAS_WIDTH, 13'd1);
            write_setting(isb_pkg::REG_CANVAS_HEIGHT, 13'd1);
            write_setting(isb_pkg::REG_CANVAS_PITCH, 13'd0);
            write_setting(isb_pkg::REG_OPTION_FLAGS, 13'd0);
        end else begin
            write_setting(isb_pkg::REG_SRC_WIDTH, pick_size(6));
            write_setting(isb_pkg::REG_SRC_HEIGHT, pick_size(6));
            write_setting(isb_pkg::REG_DEST_X, pick_position());
            write_setting(isb_pkg::REG_DEST_Y, pick_position());
            write_setting(isb_pkg::REG_CANVAS_WIDTH, pick_size(12));
            write_setting(isb_pkg::REG_CANVAS_HEIGHT, pick_size(12));
            write_setting(isb_pkg::REG_CANVAS_PITCH, pick_pitch());
            write_setting(isb_pkg::REG_OPTION_FLAGS, 13'($urandom_range(7)));
        end
    endtask

    // Loads whatever table entries a pixel of this index could read.
    task automatic make_readable(input logic [7:0] idx);
        logic [7:0]   entry;
        isb_pkg::t_in ld;
        entry         = idx;
        ld.src_index  = 8'($urandom);
        ld.dest_pixel = $urandom;
        if (planned_flags[isb_pkg::OPT_REMAP]) begin
            if (!map_loaded[idx]) begin
                ld.mode        = isb_pkg::MODE_LOAD_MAP;
                ld.table_index = idx;
                ld.table_data  = 24'($urandom);
                send_item(ld, 1'b0, '0);
            end
            entry = planned_map[idx];
        end
        if (!pal_loaded[entry]) begin
            ld.mode        = isb_pkg::MODE_LOAD_PAL;
            ld.table_index = entry;
            ld.table_data  = 24'($urandom);
            send_item(ld, 1'b0, '0);
        end
    endtask

    task automatic send_random_item();
        isb_pkg::t_in it;
        int unsigned  r;
        it.mode        = isb_pkg::MODE_PIXEL;
        it.table_index = 8'($urandom);
        it.table_data  = 24'($urandom);
        it.src_index   = 8'($urandom);
        it.dest_pixel  = $urandom;
        r = $urandom_range(99);
        if (r < 8) begin
            it.mode = isb_pkg::MODE_LOAD_PAL;
        end else if (r < 14) begin
            it.mode = isb_pkg::MODE_LOAD_MAP;
        end else if (r < 17) begin
            it.mode = MODE_UNUSED;
        end else begin
            r = $urandom_range(99);
            if (r < 20) it.src_index = isb_pkg::KEY_INDEX;
            else if (r < 35) it.src_index = isb_pkg::SHADOW_INDEX;
            make_readable(it.src_index);
        end
        send_item(it, 1'b0, '0);
    endtask

    function automatic isb_pkg::t_out result_of(input logic we,
                                                input logic [isb_pkg::ADDR_WIDTH-1:0] addr,
                                                input logic [31:0] pix, input logic last);
        isb_pkg::t_out r;
        r.write_enable = we;
        r.address      = addr;
        r.pixel_data   = pix;
        r.last         = last;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic [1:0] mode, input logic [7:0] tidx,
                                           input logic [23:0] tdata, input logic [7:0] sidx,
                                           input logic [31:0] dpix, input bit typed,
                                           input isb_pkg::t_out want);
        t_stim_row row;
        row.kind             = ROW_ITEM;
        row.reg_sel          = isb_pkg::REG_SRC_WIDTH;
        row.value            = '0;
        row.item.mode        = mode;
        row.item.table_index = tidx;
        row.item.table_data  = tdata;
        row.item.src_index   = sidx;
        row.item.dest_pixel  = dpix;
        row.typed            = typed;
        row.want             = want;
        return row;
    endfunction

    function automatic t_stim_row setting_row(input isb_pkg::t_cfg_idx sel,
                                              input logic [isb_pkg::CFG_DATA_W-1:0] value);
        t_stim_row row;
        row.kind    = ROW_SETTING;
        row.reg_sel = sel;
        row.value   = value;
        row.item    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    initial begin
        t_stim_row     rows [$];
        isb_pkg::t_out none;
        none = '0;

        rows.push_back(item_row(isb_pkg::MODE_LOAD_PAL, 8'h05, 24'h123456, 8'h00, 32'h0,
                                1, none));
        rows.push_back(item_row(isb_pkg::MODE_LOAD_PAL, 8'hff, 24'hffffff, 8'hff, '1,
                                1, none));
        rows.push_back(item_row(isb_pkg::MODE_LOAD_PAL, 8'h00, 24'h000000, 8'h00, 32'h0,
                                1, none));
        rows.push_back(item_row(isb_pkg::MODE_LOAD_MAP, 8'hff, 24'habcd05, 8'h00, 32'h0,
                                1, none));
        rows.push_back(item_row(isb_pkg::MODE_LOAD_MAP, 8'h00, 24'hffff00, 8'hff, '1,
                                1, none));
        rows.push_back(item_row(MODE_UNUSED, 8'hff, 24'hffffff, 8'hff, '1, 1, none));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h05, 32'h0, 1,
                                result_of(1'b1, '0, 32'hff123456, 1'b1)));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'hff, 24'hffffff, 8'hff, '1, 1,
                                result_of(1'b1, '0, 32'hffffffff, 1'b1)));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h00, 32'h0, 1,
                                result_of(1'b1, '0, 32'hff000000, 1'b1)));
        rows.push_back(setting_row(isb_pkg::REG_OPTION_FLAGS, 13'd7));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h00, '1, 1,
                                result_of(1'b0, '0, 32'h0, 1'b1)));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h04, '1, 1,
                                result_of(1'b1, '0, 32'hff7f7f7f, 1'b1)));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'hff, 32'h0, 1,
                                result_of(1'b1, '0, 32'hff123456, 1'b1)));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h04, 32'h0, 1,
                                result_of(1'b1, '0, 32'hff000000, 1'b1)));
        rows.push_back(setting_row(isb_pkg::REG_OPTION_FLAGS, 13'd4));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h00, 32'h0, 0, none));
        rows.push_back(setting_row(isb_pkg::REG_OPTION_FLAGS, 13'd0));
        rows.push_back(setting_row(isb_pkg::REG_SRC_WIDTH, 13'd0));
        rows.push_back(setting_row(isb_pkg::REG_SRC_HEIGHT, 13'd4095));
        rows.push_back(setting_row(isb_pkg::REG_DEST_X, 13'h0800));
        rows.push_back(setting_row(isb_pkg::REG_DEST_Y, 13'h07ff));
        rows.push_back(setting_row(isb_pkg::REG_CANVAS_WIDTH, 13'd4095));
        rows.push_back(setting_row(isb_pkg::REG_CANVAS_HEIGHT, 13'd4095));
        rows.push_back(setting_row(isb_pkg::REG_CANVAS_PITCH, 13'd8191));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h05, 32'h0, 0, none));
        rows.push_back(setting_row(isb_pkg::REG_DEST_X, 13'h07ff));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h05, 32'h0, 0, none));
        rows.push_back(setting_row(isb_pkg::REG_CANVAS_WIDTH, 13'd0));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h05, 32'h0, 0, none));
        rows.push_back(setting_row(isb_pkg::REG_SRC_WIDTH, 13'd4));
        rows.push_back(setting_row(isb_pkg::REG_SRC_HEIGHT, 13'd1));
        rows.push_back(setting_row(isb_pkg::REG_DEST_X, 13'd0));
        rows.push_back(setting_row(isb_pkg::REG_DEST_Y, 13'd0));
        rows.push_back(setting_row(isb_pkg::REG_CANVAS_WIDTH, 13'd16));
        rows.push_back(setting_row(isb_pkg::REG_CANVAS_HEIGHT, 13'd16));
        rows.push_back(setting_row(isb_pkg::REG_CANVAS_PITCH, 13'd0));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h05, 32'h0, 0, none));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'hff, '1, 0, none));
        // Shrinking the width mid-row ends the row and, with one row, the sprite.
        rows.push_back(setting_row(isb_pkg::REG_SRC_WIDTH, 13'd2));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'h05, 32'h0, 0, none));
        rows.push_back(item_row(isb_pkg::MODE_PIXEL, 8'h00, 24'h0, 8'hff, 32'h0, 0, none));

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[n]) begin
            if (rows[n].kind == ROW_SETTING) begin
                wait_idle();
                write_setting(rows[n].reg_sel, rows[n].value);
            end else begin
                send_item(rows[n].item, rows[n].typed, rows[n].want);
            end
        end

        for (int regime = 0; regime < 3; regime++) begin
            tx_idle_pct = (regime == 0) ? 22 : (regime == 1) ? 65 : 0;
            rx_idle_pct = (regime == 0) ? 65 : (regime == 1) ? 22 : 0;
            for (int phase = 0; phase < PHASES; phase++) begin
                program_phase(phase);
                for (int k = 0; k < PHASE_ITEMS; k++) begin
                    if (regime == 0 && phase == 2 && k == PHASE_ITEMS / 2) wait_idle();
                    send_random_item();
                end
            end
        end

        wait_idle();
        if (pixel_q.size() != 0) begin
            $display("%0d expected results never arrived", pixel_q.size());
            mismatches += pixel_q.size();
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
